@@ sv/tsb_pkg.sv @@
// Shared types, constants and codes for the text screen buffer.
package tsb_pkg;

   localparam int DEF_ROWS = 24;
   localparam int DEF_COLS = 40;

   // Widths of the widened row and column values used for bounds checks
   // and cell addressing (row field up to 31, column field up to 63, plus shape offset up to 2).
   localparam int ROW_XW = 7;
   localparam int COL_XW = 8;
   localparam int MUL_W  = 15;

   localparam logic [7:0] BLANK    = 8'h20;
   localparam int         SHAPE_N  = 3;

   localparam logic [23:0] SHAPE_TOP_RST    = 24'h2A202A;
   localparam logic [23:0] SHAPE_MIDDLE_RST = 24'h202A20;
   localparam logic [23:0] SHAPE_BOTTOM_RST = 24'h2A202A;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_PUT    = 3'd1,
      OP_SCROLL = 3'd2,
      OP_SHAPE  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_SHAPE_TOP    = 2'd0,
      CSR_SHAPE_MIDDLE = 2'd1,
      CSR_SHAPE_BOTTOM = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_SCR_FILL,
      ST_SHAPE,
      ST_RD_WAIT
   } state_type;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] row;
      logic [5:0] col;
      logic [7:0] ch;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic       scrolled;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic ptr_clear;
      logic ptr_inc;
      logic fill_wr;
      logic scr_rd;
      logic scr_wr;
      logic put_wr;
      logic shape_clear;
      logic shape_wr;
      logic mark_scroll;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       ptr_last;
      logic       scr_end;
      logic       shape_last;
      logic       put_wrap;
   } sts_type;

endpackage

@@ sv/tsb_ctrl.sv @@
// Controller state machine for the text screen buffer.
module tsb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tsb_pkg::sts_type sts,
   output tsb_pkg::cmd_type cmd
);

   tsb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsb_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsb_pkg::ST_INIT: begin
            if (sts.ptr_last) state_in = tsb_pkg::ST_IDLE;
         end
         tsb_pkg::ST_IDLE: begin
            if (start) state_in = tsb_pkg::ST_EXEC;
         end
         tsb_pkg::ST_EXEC: begin
            unique case (sts.op)
               tsb_pkg::OP_CLEAR:  state_in = tsb_pkg::ST_CLEAR;
               tsb_pkg::OP_PUT:    state_in = sts.put_wrap ? tsb_pkg::ST_SCR_RD
                                                           : tsb_pkg::ST_IDLE;
               tsb_pkg::OP_SCROLL: state_in = tsb_pkg::ST_SCR_RD;
               tsb_pkg::OP_SHAPE:  state_in = tsb_pkg::ST_SHAPE;
               tsb_pkg::OP_READ:   state_in = tsb_pkg::ST_RD_WAIT;
               default:            state_in = tsb_pkg::ST_IDLE;
            endcase
         end
         tsb_pkg::ST_CLEAR: begin
            if (sts.ptr_last) state_in = tsb_pkg::ST_IDLE;
         end
         tsb_pkg::ST_SCR_RD: begin
            state_in = tsb_pkg::ST_SCR_WR;
         end
         tsb_pkg::ST_SCR_WR: begin
            state_in = sts.scr_end ? tsb_pkg::ST_SCR_FILL : tsb_pkg::ST_SCR_RD;
         end
         tsb_pkg::ST_SCR_FILL: begin
            if (sts.ptr_last) state_in = tsb_pkg::ST_IDLE;
         end
         tsb_pkg::ST_SHAPE: begin
            if (sts.shape_last) state_in = tsb_pkg::ST_IDLE;
         end
         tsb_pkg::ST_RD_WAIT: begin
            state_in = tsb_pkg::ST_IDLE;
         end
         default: state_in = tsb_pkg::ST_INIT;
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         tsb_pkg::ST_INIT: begin
            cmd.fill_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         tsb_pkg::ST_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         tsb_pkg::ST_EXEC: begin
            unique case (sts.op)
               tsb_pkg::OP_CLEAR: begin
                  cmd.ptr_clear = 1'b1;
               end
               tsb_pkg::OP_PUT: begin
                  cmd.put_wr      = 1'b1;
                  cmd.ptr_clear   = 1'b1;
                  cmd.mark_scroll = sts.put_wrap;
                  cmd.respond     = !sts.put_wrap;
               end
               tsb_pkg::OP_SCROLL: begin
                  cmd.ptr_clear   = 1'b1;
                  cmd.mark_scroll = 1'b1;
               end
               tsb_pkg::OP_SHAPE: begin
                  cmd.shape_clear = 1'b1;
               end
               tsb_pkg::OP_READ: begin
                  // Cell address is already on the read port; wait for the data
               end
               default: begin
                  cmd.respond = 1'b1;
               end
            endcase
         end
         tsb_pkg::ST_CLEAR: begin
            cmd.fill_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
            cmd.respond = sts.ptr_last;
         end
         tsb_pkg::ST_SCR_RD: begin
            cmd.scr_rd = 1'b1;
         end
         tsb_pkg::ST_SCR_WR: begin
            cmd.scr_wr  = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         tsb_pkg::ST_SCR_FILL: begin
            cmd.fill_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
            cmd.respond = sts.ptr_last;
         end
         tsb_pkg::ST_SHAPE: begin
            cmd.shape_wr = 1'b1;
            cmd.respond  = sts.shape_last;
         end
         tsb_pkg::ST_RD_WAIT: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/tsb_datapath.sv @@
// Datapath of the text screen buffer: cell store, pointers, pattern registers.
module tsb_datapath #(
   parameter int ROWS = tsb_pkg::DEF_ROWS,
   parameter int COLS = tsb_pkg::DEF_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  tsb_pkg::req_type req_data,
   input  logic             csr_wr,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_data,
   input  tsb_pkg::cmd_type cmd,
   output tsb_pkg::sts_type sts,
   output logic             rsp_valid,
   output tsb_pkg::rsp_type rsp_data
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SCR_END_ADDR = ADDR_W'(CELLS - COLS - 1);
   localparam logic [ADDR_W-1:0] WRAP_ADDR    = ADDR_W'((ROWS - 1) * COLS);
   localparam logic [ADDR_W-1:0] COLS_A       = ADDR_W'(COLS);

   localparam logic [tsb_pkg::ROW_XW-1:0] ROWS_V = tsb_pkg::ROW_XW'(ROWS);
   localparam logic [tsb_pkg::COL_XW-1:0] COLS_V = tsb_pkg::COL_XW'(COLS);

   logic [7:0] mem [CELLS];

   tsb_pkg::req_type     req_ff;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [1:0]           si_ff, si_in, sj_ff, sj_in;
   logic [23:0]          shape_ff [tsb_pkg::SHAPE_N];
   logic                 scrolled_ff;
   logic [7:0]           rdata_ff;
   logic                 rsp_valid_ff;
   tsb_pkg::rsp_type     rsp_ff;

   logic [tsb_pkg::ROW_XW-1:0] row_x, tr, rr;
   logic [tsb_pkg::COL_XW-1:0] col_x, tc, cc;
   logic [tsb_pkg::MUL_W-1:0]  shape_prod, read_prod, start_prod;
   logic [ADDR_W-1:0]          put_addr, waddr, raddr;
   logic [7:0]                 wdata, shape_byte;
   logic                       we, shape_in, read_in;

   assign row_x = tsb_pkg::ROW_XW'(req_ff.row);
   assign col_x = tsb_pkg::COL_XW'(req_ff.col);

   // Clamp the put start to the screen
   assign rr = (row_x < ROWS_V) ? row_x : ROWS_V - 1'b1;
   assign cc = (col_x < COLS_V) ? col_x : COLS_V - 1'b1;

   assign start_prod = tsb_pkg::MUL_W'(rr) * tsb_pkg::MUL_W'(COLS_V)
                     + tsb_pkg::MUL_W'(cc);
   assign put_addr   = req_ff.start_req ? ADDR_W'(start_prod) : pos_ff;

   assign read_in   = (row_x < ROWS_V) && (col_x < COLS_V);
   assign read_prod = tsb_pkg::MUL_W'(row_x) * tsb_pkg::MUL_W'(COLS_V)
                    + tsb_pkg::MUL_W'(col_x);

   // Current pattern cell
   assign tr         = row_x + tsb_pkg::ROW_XW'(si_ff);
   assign tc         = col_x + tsb_pkg::COL_XW'(sj_ff);
   assign shape_in   = (tr < ROWS_V) && (tc < COLS_V);
   assign shape_prod = tsb_pkg::MUL_W'(tr) * tsb_pkg::MUL_W'(COLS_V)
                     + tsb_pkg::MUL_W'(tc);

   always_comb begin
      unique case (sj_ff)
         2'd0:    shape_byte = shape_ff[si_ff][23:16];
         2'd1:    shape_byte = shape_ff[si_ff][15:8];
         default: shape_byte = shape_ff[si_ff][7:0];
      endcase
   end

   // Write port select
   always_comb begin
      we    = 1'b0;
      waddr = ptr_ff;
      wdata = tsb_pkg::BLANK;
      priority if (cmd.fill_wr) begin
         we = 1'b1;
      end else if (cmd.scr_wr) begin
         we    = 1'b1;
         wdata = rdata_ff;
      end else if (cmd.put_wr) begin
         we    = 1'b1;
         waddr = put_addr;
         wdata = req_ff.ch;
      end else if (cmd.shape_wr) begin
         we    = shape_in;
         waddr = ADDR_W'(shape_prod);
         wdata = shape_byte;
      end
   end

   assign raddr = cmd.scr_rd ? ptr_ff + COLS_A : ADDR_W'(read_prod);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      ptr_in = ptr_ff;
      priority if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.put_wr) begin
         pos_in = (put_addr == LAST_ADDR) ? WRAP_ADDR : put_addr + 1'b1;
      end
   end

   always_comb begin
      si_in = si_ff;
      sj_in = sj_ff;
      priority if (cmd.shape_clear) begin
         si_in = '0;
         sj_in = '0;
      end else if (cmd.shape_wr) begin
         if (sj_ff == 2'd2) begin
            sj_in = '0;
            si_in = si_ff + 1'b1;
         end else begin
            sj_in = sj_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         pos_ff       <= '0;
         si_ff        <= '0;
         sj_ff        <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shape_ff[tsb_pkg::CSR_SHAPE_TOP]    <= tsb_pkg::SHAPE_TOP_RST;
         shape_ff[tsb_pkg::CSR_SHAPE_MIDDLE] <= tsb_pkg::SHAPE_MIDDLE_RST;
         shape_ff[tsb_pkg::CSR_SHAPE_BOTTOM] <= tsb_pkg::SHAPE_BOTTOM_RST;
      end else begin
         ptr_ff       <= ptr_in;
         pos_ff       <= pos_in;
         si_ff        <= si_in;
         sj_ff        <= sj_in;
         rsp_valid_ff <= cmd.respond;
         if (cmd.latch) begin
            scrolled_ff <= 1'b0;
         end else if (cmd.mark_scroll) begin
            scrolled_ff <= 1'b1;
         end
         if (csr_wr && (csr_index <= tsb_pkg::CSR_SHAPE_BOTTOM)) begin
            shape_ff[csr_index] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.respond) begin
         rsp_ff.scrolled  <= scrolled_ff;
         rsp_ff.read_char <= ((req_ff.op == tsb_pkg::OP_READ) && read_in) ? rdata_ff : 8'd0;
      end
   end

   assign sts.op         = req_ff.op;
   assign sts.ptr_last   = (ptr_ff == LAST_ADDR);
   assign sts.scr_end    = (ptr_ff == SCR_END_ADDR);
   assign sts.shape_last = (si_ff == 2'd2) && (sj_ff == 2'd2);
   assign sts.put_wrap   = (put_addr == LAST_ADDR);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/text_screen_buffer_with_scroll.sv @@
// Top level of the text screen buffer with scroll.
//
// A ROWS x COLS character store, one byte per cell, held in a single-port
// write / single-port read memory with registered read data.
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; req_data carries op, row, col, ch and start_req. Every command
// returns exactly one result on rsp_data, marked by a one-cycle rsp_valid
// strobe. The receiver cannot stall; results are never held.
// Configuration: csr_valid / csr_ready write of the three pattern rows
// (index 0 top, 1 middle, 2 bottom); csr_ready is always high. Indexes past
// the list are dropped. Write only while no command is in flight.
// Work per command: a put or unused code responds from its execute state, a
// read waits for the registered read data, shape writes one pattern cell per
// cycle, clear fills every cell with spaces, and scroll reads and then writes
// each moved cell on the one memory port pair, then blanks the bottom row. A put that fills the last cell runs the
// scroll right after its write and takes exactly as long as a scroll.
// busy drops the cycle the strobe shows, so the next command may follow;
// a new command is taken only after the last one has given its result.
// Reset: after reset falls, a clearing pass writes spaces to all ROWS*COLS
// cells, one per cycle, with busy high; configuration writes still land.
module text_screen_buffer_with_scroll #(
   parameter int ROWS = tsb_pkg::DEF_ROWS,
   parameter int COLS = tsb_pkg::DEF_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tsb_pkg::req_type req_data,
   output logic             rsp_valid,
   output tsb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_data
);

   tsb_pkg::cmd_type cmd;
   tsb_pkg::sts_type sts;

   // Pattern registers take a write in any cycle out of reset
   assign csr_ready = 1'b1;

   tsb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   tsb_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // An accepted transaction must take the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   // One command, one result: strobes never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // A scrolling command never carries read data
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.scrolled && (rsp_data.read_char != 8'd0)))
      else $error("result both scrolled and carries read data");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the text screen buffer with scroll.
module tb_top;
   import tsb_pkg::*;

   localparam int ROWS  = DEF_ROWS;
   localparam int COLS  = DEF_COLS;
   localparam int CELLS = ROWS * COLS;

   // Longest command: a scroll walks the store with a read and a write per cell.
   localparam int SCROLL_CYCLES = 2 * (ROWS - 1) * COLS + COLS + 2;
   localparam int DRAIN_CYCLES  = SCROLL_CYCLES + 16;
   localparam int RANDOM_ITEMS  = 1925;
   localparam int PHASES        = 4;
   localparam int MAX_GAP       = 12;
   // Slowest legal run: every command a put that wraps into a scroll, plus the
   // longest sender gap, plus the clearing pass after reset; then margin.
   localparam int LIMIT_CYCLES  =
      4 * (CELLS + 2000 * (SCROLL_CYCLES + 2 + MAX_GAP) + 10000);

   // Op codes the block ignores.
   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;
   // Register index past the list; the write is dropped.
   localparam logic [1:0] CSR_RSVD = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   req_type     req_data  = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data  = '0;

   text_screen_buffer_with_scroll #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Screen image, put pointer and pattern registers as the block should hold them.
   logic [7:0]  screen_img [CELLS];
   logic [9:0]  put_pos;
   logic [23:0] pattern_rows [SHAPE_N];
   rsp_type     screen_rsp_q [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int burst_left     = 0;
   int cycle_count    = 0;

   // Directed commands; typed = 1 marks a result fixed by inspection.
   typedef struct packed {
      req_type cmd;
      logic    typed;
      rsp_type want;
   } directed_row;

   localparam int N_DIRECTED = 26;
   directed_row directed_steps [N_DIRECTED] = '{
      '{'{OP_READ,   5'd0,  6'd0,  8'h00, 1'b0}, 1'b1, '{BLANK, 1'b0}}, // blank after reset
      '{'{OP_READ,   5'd23, 6'd39, 8'h00, 1'b0}, 1'b1, '{BLANK, 1'b0}},
      '{'{OP_READ,   5'd24, 6'd0,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}}, // row off screen
      '{'{OP_READ,   5'd0,  6'd40, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}}, // column off screen
      '{'{OP_READ,   5'd31, 6'd63, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
      '{'{OP_RSVD5,  5'd0,  6'd0,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
      '{'{OP_RSVD7,  5'd31, 6'd63, 8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0}},
      '{'{OP_PUT,    5'd0,  6'd0,  8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0}},
      '{'{OP_READ,   5'd0,  6'd0,  8'h00, 1'b0}, 1'b1, '{8'hFF, 1'b0}},
      '{'{OP_PUT,    5'd31, 6'd63, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}}, // running pointer
      '{'{OP_READ,   5'd0,  6'd1,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
      '{'{OP_PUT,    5'd31, 6'd63, 8'h41, 1'b1}, 1'b1, '{8'h00, 1'b1}}, // clamp to last cell, wrap
      '{'{OP_READ,   5'd22, 6'd39, 8'h00, 1'b0}, 1'b1, '{8'h41, 1'b0}},
      '{'{OP_READ,   5'd23, 6'd39, 8'h00, 1'b0}, 1'b1, '{BLANK, 1'b0}},
      '{'{OP_PUT,    5'd0,  6'd0,  8'h42, 1'b0}, 1'b1, '{8'h00, 1'b0}}, // bottom row start
      '{'{OP_READ,   5'd23, 6'd0,  8'h00, 1'b0}, 1'b1, '{8'h42, 1'b0}},
      '{'{OP_PUT,    5'd5,  6'd63, 8'h43, 1'b1}, 1'b1, '{8'h00, 1'b0}}, // column clamp only
      '{'{OP_READ,   5'd5,  6'd39, 8'h00, 1'b0}, 1'b1, '{8'h43, 1'b0}},
      '{'{OP_SHAPE,  5'd22, 6'd38, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}}, // clipped corner
      '{'{OP_READ,   5'd23, 6'd39, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{OP_READ,   5'd22, 6'd39, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{OP_SHAPE,  5'd31, 6'd63, 8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}}, // fully off screen
      '{'{OP_SCROLL, 5'd0,  6'd0,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1}},
      '{'{OP_CLEAR,  5'd0,  6'd0,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
      '{'{OP_READ,   5'd21, 6'd39, 8'h00, 1'b0}, 1'b1, '{BLANK, 1'b0}},
      '{'{OP_RSVD6,  5'd12, 6'd20, 8'h5A, 1'b1}, 1'b1, '{8'h00, 1'b0}}
   };

   function automatic req_type make_cmd(input logic [2:0] op, input int row, input int col,
                                        input int ch, input logic use_start);
      req_type c;
      c.op        = op;
      c.row       = 5'(row);
      c.col       = 6'(col);
      c.ch        = 8'(ch);
      c.start_req = use_start;
      return c;
   endfunction

   task automatic scroll_img();
      for (int k = 0; k < CELLS - COLS; k++) screen_img[k] = screen_img[k + COLS];
      for (int k = CELLS - COLS; k < CELLS; k++) screen_img[k] = BLANK;
   endtask

   // Advance the screen image by one command and return the result it should give.
   task automatic apply_screen_cmd(input req_type cmd, output rsp_type outcome);
      int r_eff;
      int c_eff;
      int tr;
      int tc;
      outcome = '0;
      case (cmd.op)
         OP_CLEAR: begin
            for (int k = 0; k < CELLS; k++) screen_img[k] = BLANK;
         end
         OP_PUT: begin
            if (cmd.start_req) begin
               r_eff   = (cmd.row < ROWS) ? int'(cmd.row) : ROWS - 1;
               c_eff   = (cmd.col < COLS) ? int'(cmd.col) : COLS - 1;
               put_pos = 10'(r_eff * COLS + c_eff);
            end
            if (put_pos >= CELLS) put_pos = '0;
            screen_img[put_pos] = cmd.ch;
            put_pos = put_pos + 10'd1;
            // Writing the last cell wraps: scroll, park at the bottom row start.
            if (put_pos >= CELLS) begin
               put_pos = 10'((ROWS - 1) * COLS);
               scroll_img();
               outcome.scrolled = 1'b1;
            end
         end
         OP_SCROLL: begin
            scroll_img();
            outcome.scrolled = 1'b1;
         end
         OP_SHAPE: begin
            // Clip cells past the right or bottom edge; spaces overwrite too.
            for (int i = 0; i < SHAPE_N; i++) begin
               for (int j = 0; j < SHAPE_N; j++) begin
                  tr = int'(cmd.row) + i;
                  tc = int'(cmd.col) + j;
                  if (tr < ROWS && tc < COLS)
                     screen_img[tr * COLS + tc] = 8'(pattern_rows[i] >> (16 - 8 * j));
               end
            end
         end
         OP_READ: begin
            if (cmd.row < ROWS && cmd.col < COLS)
               outcome.read_char = screen_img[int'(cmd.row) * COLS + int'(cmd.col)];
         end
         default: ;
      endcase
   endtask

   // Hold the command until the block takes it, log the expected result, then
   // either stay in the burst or drop start for a random gap.
   task automatic issue(input req_type cmd, input logic typed, input rsp_type want);
      rsp_type predicted;
      int gap;
      req_data <= cmd;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      apply_screen_cmd(cmd, predicted);
      screen_rsp_q.push_back(typed ? want : predicted);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap   = $urandom_range(1, MAX_GAP);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic await_results();
      if (start) start <= 1'b0;
      while (screen_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < SHAPE_N) pattern_rows[idx] = value;
   endtask

   // Load all three pattern rows while the block is idle; include one dropped index.
   task automatic program_shape(input logic [23:0] top, input logic [23:0] mid,
                                input logic [23:0] bot);
      await_results();
      csr_write(CSR_SHAPE_TOP, top);
      csr_write(CSR_SHAPE_MIDDLE, mid);
      csr_write(CSR_SHAPE_BOTTOM, bot);
      csr_write(CSR_RSVD, ~top);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Compare each strobed result with the oldest pending expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (screen_rsp_q.size() == 0) begin
            $display("%0t: unexpected result, read_char %h scrolled %b", $time,
                     rsp_data.read_char, rsp_data.scrolled);
            mismatch_count++;
         end else begin
            want = screen_rsp_q.pop_front();
            if (rsp_data.read_char !== want.read_char) begin
               $display("%0t: read_char expected %h, got %h", $time,
                        want.read_char, rsp_data.read_char);
               mismatch_count++;
            end
            if (rsp_data.scrolled !== want.scrolled) begin
               $display("%0t: scrolled expected %b, got %b", $time,
                        want.scrolled, rsp_data.scrolled);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int phase_end;
      int pick;
      int n;
      int r0;
      int c0;
      logic [23:0] pat;

      for (int k = 0; k < CELLS; k++) screen_img[k] = BLANK;
      put_pos         = '0;
      pattern_rows[0] = SHAPE_TOP_RST;
      pattern_rows[1] = SHAPE_MIDDLE_RST;
      pattern_rows[2] = SHAPE_BOTTOM_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass with the reset patterns; issue waits out the clearing pass.
      for (int s = 0; s < N_DIRECTED; s++)
         issue(directed_steps[s].cmd, directed_steps[s].typed, directed_steps[s].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) begin
            program_shape(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
         end else if (ph == 1) begin
            program_shape(24'h000000, 24'h000000, 24'h000000);
         end else begin
            pat = 24'($urandom);
            program_shape(pat, 24'($urandom), 24'($urandom));
         end
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               // Single mixed command, noise included.
               n  = $urandom_range(0, 99);
               r0 = $urandom_range(0, 31);
               c0 = $urandom_range(0, 63);
               if (n < 35) begin
                  issue(make_cmd(OP_PUT, r0, c0, $urandom, 1'($urandom)), 1'b0, '0);
               end else if (n < 70) begin
                  if (n < 64) begin
                     r0 = $urandom_range(0, ROWS - 1);
                     c0 = $urandom_range(0, COLS - 1);
                  end
                  issue(make_cmd(OP_READ, r0, c0, $urandom, 1'($urandom)), 1'b0, '0);
               end else if (n < 85) begin
                  issue(make_cmd(OP_SHAPE, $urandom_range(0, ROWS + 1),
                                 $urandom_range(0, COLS + 1), $urandom, 1'($urandom)),
                        1'b0, '0);
               end else if (n < 91) begin
                  issue(make_cmd(3'($urandom_range(OP_RSVD5, OP_RSVD7)), r0, c0, $urandom,
                                 1'($urandom)), 1'b0, '0);
               end else if (n < 96) begin
                  issue(make_cmd(OP_SCROLL, r0, c0, $urandom, 1'($urandom)), 1'b0, '0);
               end else begin
                  issue(make_cmd(OP_CLEAR, r0, c0, $urandom, 1'($urandom)), 1'b0, '0);
               end
            end else if (pick < 70) begin
               // Text run: position once, then stream characters.
               issue(make_cmd(OP_PUT, $urandom_range(0, 31), $urandom_range(0, 63),
                              $urandom, 1'b1), 1'b0, '0);
               n = $urandom_range(2, 12);
               repeat (n)
                  issue(make_cmd(OP_PUT, $urandom_range(0, 31), $urandom_range(0, 63),
                                 $urandom, 1'b0), 1'b0, '0);
            end else if (pick < 88) begin
               // Read back around the row being written.
               n = $urandom_range(1, 8);
               repeat (n) begin
                  r0 = ($urandom_range(0, 1) == 0) ? int'(put_pos) / COLS
                                                   : $urandom_range(0, ROWS - 1);
                  issue(make_cmd(OP_READ, r0, $urandom_range(0, COLS - 1), 0, 1'b0),
                        1'b0, '0);
               end
            end else if (pick < 95) begin
               // Place a pattern and read its whole footprint.
               r0 = $urandom_range(0, ROWS);
               c0 = $urandom_range(0, COLS);
               issue(make_cmd(OP_SHAPE, r0, c0, $urandom, 1'b0), 1'b0, '0);
               for (int i = 0; i < SHAPE_N; i++)
                  for (int j = 0; j < SHAPE_N; j++)
                     issue(make_cmd(OP_READ, r0 + i, c0 + j, 0, 1'b0), 1'b0, '0);
            end else if (pick < 99) begin
               // Run off the last cell so the put itself scrolls the screen.
               n = $urandom_range(0, 6);
               issue(make_cmd(OP_PUT, ROWS - 1, COLS - 1 - n, $urandom, 1'b1), 1'b0, '0);
               repeat (n + $urandom_range(1, 3))
                  issue(make_cmd(OP_PUT, 0, 0, $urandom, 1'b0), 1'b0, '0);
               issue(make_cmd(OP_READ, ROWS - 2, COLS - 1, 0, 1'b0), 1'b0, '0);
               issue(make_cmd(OP_READ, ROWS - 1, 0, 0, 1'b0), 1'b0, '0);
            end else begin
               // Drain everything before going on.
               await_results();
            end
         end
      end

      await_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && screen_rsp_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
